/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the Huffman bit packer RTL. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define HCBP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HCBP_ASSERT(label, clk, rst_n, prop, msg)
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants, command codes and word types of the Huffman bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

	// Field widths of the input and output words.
	localparam int CMD_W   = 2;
	localparam int SYM_W   = 9;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;

	// Longest code that a table entry keeps; longer loads saturate.
	localparam int MAX_CODE_LEN = 32;

	// Code table geometry: 256 byte symbols plus the end-of-file slot.
	localparam int NUM_SLOTS = 257;
	localparam int EOF_SLOT  = 256;
	localparam int ADDR_W    = $clog2(NUM_SLOTS);

	// Bit accumulator: up to seven leftover bits plus one whole code.
	localparam int PEND_W = BYTE_W - 1;
	localparam int ACC_W  = PEND_W + MAX_CODE_LEN;
	localparam int CNT_W  = $clog2(ACC_W + 1);

	// Queue between the lookup front and the packing back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Command codes; the fourth code is unused and does nothing.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	// One code table entry.
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} table_entry_t;

	localparam int ENTRY_W = $bits(table_entry_t);

	// One job for the packing back: a looked-up code and the finish flag.
	typedef struct packed {
		logic         fin;
		table_entry_t ent;
	} job_t;

endpackage

`default_nettype wire

/* hdl/hcbp_in_if.sv */
// ----------------------------------------------------------------------------
// hcbp_in_if
// Command channel of the bit packer: valid/ready handshake and the command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_in_if;

	logic                          valid;
	logic                          ready;
	logic [hcbp_pkg::CMD_W-1:0]    command;
	logic [hcbp_pkg::SYM_W-1:0]    symbol;
	logic [hcbp_pkg::CODE_W-1:0]   code_bits;
	logic [hcbp_pkg::LEN_W-1:0]    code_length;

	modport source (
		output valid, command, symbol, code_bits, code_length,
		input  ready
	);

	modport sink (
		input  valid, command, symbol, code_bits, code_length,
		output ready
	);

endinterface

`default_nettype wire

/* hdl/hcbp_out_if.sv */
// ----------------------------------------------------------------------------
// hcbp_out_if
// Byte channel of the bit packer: valid/ready handshake and the packed word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_out_if;

	logic                          valid;
	logic                          ready;
	logic [hcbp_pkg::BYTE_W-1:0]   packed_byte;
	logic                          last;

	modport source (
		output valid, packed_byte, last,
		input  ready
	);

	modport sink (
		input  valid, packed_byte, last,
		output ready
	);

endinterface

`default_nettype wire

/* hdl/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/hcbp_front.sv */
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts command words, writes the code table on loads and looks up codes
// for encode and finish commands, pushing each lookup into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	hcbp_in_if.sink                            req,
	input  wire logic [hcbp_pkg::QCNT_W-1:0]   q_count,
	output logic                               push_valid,
	output hcbp_pkg::job_t                     push_data
);

	logic                                 accept;
	logic                                 sym_ok;
	logic [hcbp_pkg::QCNT_W:0]            in_flight;
	logic                                 wr_en;
	logic                                 rd_en;
	logic                                 rd_fin;
	logic [hcbp_pkg::ADDR_W-1:0]          rd_addr;
	logic [hcbp_pkg::LEN_W-1:0]           sat_len;
	hcbp_pkg::table_entry_t               wr_entry;
	logic [hcbp_pkg::ENTRY_W-1:0]         rd_data;
	logic                                 valid_s1;
	logic                                 fin_s1;

	// Take a word only while the queue has room for every lookup in flight.
	assign in_flight = {1'b0, q_count} + (hcbp_pkg::QCNT_W + 1)'(valid_s1);
	assign req.ready = in_flight < (hcbp_pkg::QCNT_W + 1)'(hcbp_pkg::QUEUE_DEPTH);
	assign accept    = req.valid && req.ready;
	assign sym_ok    = req.symbol <= hcbp_pkg::SYM_W'(hcbp_pkg::EOF_SLOT);

	// Saturate the loaded length to the longest code the table keeps.
	always_comb begin
		if (req.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) begin
			sat_len = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
		end else begin
			sat_len = req.code_length;
		end
	end

	assign wr_entry.len  = sat_len;
	assign wr_entry.code = req.code_bits;

	// Decode the command into a table write or a table lookup.
	always_comb begin
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		rd_fin  = 1'b0;
		rd_addr = hcbp_pkg::ADDR_W'(req.symbol);
		case (hcbp_pkg::cmd_t'(req.command))
			hcbp_pkg::CMD_LOAD: begin
				wr_en = accept && sym_ok;
			end
			hcbp_pkg::CMD_ENCODE: begin
				rd_en = accept && sym_ok;
			end
			hcbp_pkg::CMD_FINISH: begin
				rd_en   = accept;
				rd_fin  = 1'b1;
				rd_addr = hcbp_pkg::ADDR_W'(hcbp_pkg::EOF_SLOT);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	hcbp_ram #(
		.WIDTH (hcbp_pkg::ENTRY_W),
		.DEPTH (hcbp_pkg::NUM_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (hcbp_pkg::ADDR_W'(req.symbol)),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Lookup stage: the table data arrives in the cycle after the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fin_s1 <= rd_fin;
		end
	end

	assign push_valid    = valid_s1;
	assign push_data.fin = fin_s1;
	assign push_data.ent = hcbp_pkg::table_entry_t'(rd_data);

endmodule

`default_nettype wire

/* hdl/hcbp_fifo.sv */
// ----------------------------------------------------------------------------
// hcbp_fifo
// Short job queue between the lookup front and the packing back.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push_valid,
	input  wire hcbp_pkg::job_t                push_data,
	output logic                               pop_valid,
	input  wire logic                          pop_ready,
	output hcbp_pkg::job_t                     pop_data,
	output logic [hcbp_pkg::QCNT_W-1:0]        count
);

	hcbp_pkg::job_t                  mem_q [hcbp_pkg::QUEUE_DEPTH];
	logic [hcbp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [hcbp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [hcbp_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign do_push   = push_valid && (count_q != hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH));
	assign do_pop    = pop_ready && (count_q != '0);
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign count     = count_q;

	// Storage for the queued jobs.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == hcbp_pkg::QPTR_W'(hcbp_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == hcbp_pkg::QPTR_W'(hcbp_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/hcbp_back.sv */
// ----------------------------------------------------------------------------
// hcbp_back
// Packs looked-up codes into a bit accumulator and emits one byte per cycle,
// while rsp is ready, through an output register; a finish job pads and
// flags the final byte.
`default_nettype none

module hcbp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pop_valid,
	output logic                     pop_ready,
	input  wire hcbp_pkg::job_t      pop_data,
	hcbp_out_if.source               rsp
);

	logic [hcbp_pkg::ACC_W-1:0]      acc_q;
	logic [hcbp_pkg::CNT_W-1:0]      cnt_q;
	logic                            fin_q;
	logic                            out_valid_q;
	logic [hcbp_pkg::BYTE_W-1:0]     byte_q;
	logic                            last_q;

	logic                            full;
	logic                            need;
	logic                            emit;
	logic                            load;
	logic [hcbp_pkg::CNT_W-1:0]      sh;
	logic [3:0]                      pad_sh;
	logic [hcbp_pkg::BYTE_W-1:0]     full_byte;
	logic [hcbp_pkg::BYTE_W-1:0]     pad_byte;
	logic [hcbp_pkg::BYTE_W-1:0]     emit_byte;
	logic                            emit_last;
	logic [hcbp_pkg::CNT_W-1:0]      cnt_after;
	logic                            fin_after;
	logic                            need_after;
	logic [hcbp_pkg::CNT_W-1:0]      base_cnt;
	logic [hcbp_pkg::ACC_W-1:0]      code_ext;
	logic [hcbp_pkg::ACC_W-1:0]      code_mask;
	logic [hcbp_pkg::ACC_W-1:0]      new_acc;
	logic [hcbp_pkg::CNT_W-1:0]      new_cnt;

	// A byte is due while eight or more bits are pending or a finish waits to flush.
	assign full = cnt_q >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
	assign need = full || fin_q;
	assign emit = need && (!out_valid_q || rsp.ready);

	// Oldest eight pending bits, and the leftover bits padded with zeros.
	assign sh        = cnt_q - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
	assign full_byte = hcbp_pkg::BYTE_W'(acc_q >> sh);
	assign pad_sh    = 4'(hcbp_pkg::BYTE_W) - 4'(cnt_q);
	assign pad_byte  = hcbp_pkg::BYTE_W'({1'b0, acc_q[hcbp_pkg::PEND_W-1:0]} << pad_sh);

	// Select the word to emit and the accumulator state it leaves behind.
	always_comb begin
		if (full) begin
			emit_byte = full_byte;
			emit_last = fin_q && (cnt_q == hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W));
			cnt_after = sh;
			fin_after = fin_q && (cnt_q != hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W));
		end else begin
			emit_byte = pad_byte;
			emit_last = 1'b1;
			cnt_after = '0;
			fin_after = 1'b0;
		end
	end

	assign need_after = (cnt_after >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) || fin_after;

	// A new job enters once the current one has no more bytes to give.
	assign pop_ready = !need || (emit && !need_after);
	assign load      = pop_ready && pop_valid;
	assign base_cnt  = emit ? cnt_after : cnt_q;

	// Append the new code below the leftover bits.
	assign code_ext  = hcbp_pkg::ACC_W'(pop_data.ent.code);
	assign code_mask = ~({hcbp_pkg::ACC_W{1'b1}} << pop_data.ent.len);
	assign new_acc   = ({{(hcbp_pkg::ACC_W - hcbp_pkg::PEND_W){1'b0}},
		acc_q[hcbp_pkg::PEND_W-1:0]} << pop_data.ent.len) | (code_ext & code_mask);
	assign new_cnt   = base_cnt + hcbp_pkg::CNT_W'(pop_data.ent.len);

	// Accumulator bits carry no reset; only bits below the count are used.
	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= new_acc;
		end
	end

	// Pending count and finish flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (load) begin
			cnt_q <= new_cnt;
			fin_q <= pop_data.fin;
		end else if (emit) begin
			cnt_q <= cnt_after;
			fin_q <= fin_after;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.packed_byte = byte_q;
	assign rsp.last        = last_q;

endmodule

`default_nettype wire

/* hdl/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven Huffman bit packer with an end-of-file code.
//
// The req channel takes command words: load writes one entry of the
// 257-slot code table, encode appends the code of a byte symbol, finish
// appends the end-of-file code, pads to a byte and flags the final word
// with last. The rsp channel returns packed bytes, earliest bit in bit 7.
// Both channels use a valid/ready handshake.
// A lookup word passes the table read register, the job queue, the
// accumulator and the output register before its first byte appears on
// rsp. The front takes one word per cycle while the four-entry job queue
// has room. The back emits one byte per cycle while rsp is ready, and takes
// the next job in the cycle that emits the last byte of the current one;
// the back has a single byte emitter for every job.
// When rsp stalls the output register holds its word, the queue fills and
// req.ready drops. Reset clears the accumulator count, the queue and the
// output register; the code table is not cleared and must be loaded
// before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module huffman_code_bit_packer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hcbp_in_if.sink    req,
	hcbp_out_if.source rsp
);

	logic                              push_valid;
	hcbp_pkg::job_t                    push_data;
	logic                              pop_valid;
	logic                              pop_ready;
	hcbp_pkg::job_t                    pop_data;
	logic [hcbp_pkg::QCNT_W-1:0]       q_count;

	// Command decode and code table lookup.
	hcbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.q_count    (q_count),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// Job queue between lookup and packing.
	hcbp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.count      (q_count)
	);

	// Bit accumulator and byte output.
	hcbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

	// The queue never holds more jobs than it has entries.
	`HCBP_ASSERT(a_queue_bound, clk, arst_n, q_count <= hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH), "job queue overfilled")

	// An accepted encode of a valid symbol becomes a plain job in the next cycle.
	`HCBP_ASSERT_NEXT(a_encode_push, clk, arst_n, req.valid && req.ready && req.command == hcbp_pkg::CMD_ENCODE && req.symbol <= hcbp_pkg::SYM_W'(hcbp_pkg::EOF_SLOT), push_valid && !push_data.fin, "encode lookup lost")

	// An accepted finish becomes a finish job in the next cycle.
	`HCBP_ASSERT_NEXT(a_finish_push, clk, arst_n, req.valid && req.ready && req.command == hcbp_pkg::CMD_FINISH, push_valid && push_data.fin, "finish lookup lost")

	// A table load never creates a job.
	`HCBP_ASSERT_NEXT(a_load_silent, clk, arst_n, req.valid && req.ready && req.command == hcbp_pkg::CMD_LOAD, !push_valid, "load produced a job")

endmodule

`default_nettype wire
